FILE: sv/dop_pkg.sv
// Shared types, register indexes, marker constants and the bit-reversal
// helper for the DSD-over-PCM packer. No dependencies.
`default_nettype none

package dop_pkg;

  // Register map of the configuration write channel.
  typedef enum logic [1:0] {
    REG_CHAN_COUNT = 2'd0,
    REG_NATIVE     = 2'd1,
    REG_PER_SAMPLE = 2'd2,
    REG_SAMPLES    = 2'd3
  } reg_idx_t;

  localparam int unsigned MAX_CHANNELS_DEF = 8;

  // Wide enough to hold any effective channel count (up to 15).
  localparam int unsigned CHAN_W = 5;

  localparam logic [3:0]  CHAN_COUNT_RST = 4'd2;
  localparam logic [7:0]  MARK_EVEN      = 8'hFA;
  localparam logic [7:0]  MARK_ODD       = 8'h05;
  localparam logic [7:0]  SWAP_MASK_1    = 8'h55;
  localparam logic [7:0]  SWAP_MASK_2    = 8'h33;
  localparam logic [7:0]  SWAP_MASK_4    = 8'h0F;

  // Static settings handed from the register block to the datapath.
  typedef struct packed {
    logic [3:0]  chan_count;
    logic        native;
    logic        per_sample;
    logic [63:0] limit_dop;   // ceil(samples / 16), in output frames
    logic [63:0] limit_nat;   // ceil(samples / 8), in output frames
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [23:0] word;
    logic [2:0]  slot;
    logic        last;
  } result_t;

  // Reverse the bit order of a byte by swapping bits, pairs and nibbles.
  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] t;
    t = ((v >> 1) & SWAP_MASK_1) | ((v & SWAP_MASK_1) << 1);
    t = ((t >> 2) & SWAP_MASK_2) | ((t & SWAP_MASK_2) << 2);
    t = ((t >> 4) & SWAP_MASK_4) | ((t & SWAP_MASK_4) << 4);
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dop_cfg.sv
// Configuration registers of the DSD-over-PCM packer, including the
// registered end-of-stream frame limits. Depends on dop_pkg.
`default_nettype none

module dop_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data,
  output dop_pkg::cfg_t      cfg
);
  import dop_pkg::*;

  logic [3:0]  chan_count;
  logic        native;
  logic        per_sample;
  logic [63:0] samples;
  logic [63:0] limit_dop;
  logic [63:0] limit_nat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= CHAN_COUNT_RST;
      native     <= 1'b0;
      per_sample <= 1'b0;
      samples    <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_CHAN_COUNT: chan_count <= cfg_data[3:0];
        REG_NATIVE:     native     <= cfg_data[0];
        REG_PER_SAMPLE: per_sample <= cfg_data[0];
        REG_SAMPLES:    samples    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limits registered from samples; user must write only while idle (unenforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_dop <= '0;
      limit_nat <= '0;
    end else begin
      limit_dop <= (samples >> 4) + {63'd0, |samples[3:0]};
      limit_nat <= (samples >> 3) + {63'd0, |samples[2:0]};
    end
  end

  always_comb begin
    cfg.chan_count = chan_count;
    cfg.native     = native;
    cfg.per_sample = per_sample;
    cfg.limit_dop  = limit_dop;
    cfg.limit_nat  = limit_nat;
  end

endmodule

`default_nettype wire

FILE: sv/dop_pack.sv
// Input register, frame state and single-pass packing logic of the
// DSD-over-PCM packer. Depends on dop_pkg.
`default_nettype none

module dop_pack #(
  parameter int unsigned MAX_CHANNELS = dop_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  dop_pkg::cfg_t      cfg,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          out_free,
  output logic               res_load,
  output dop_pkg::result_t   res
);
  import dop_pkg::*;

  localparam int unsigned PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic              in_valid;
  logic [7:0]        in_byte;
  logic [PW-1:0]     pos;
  logic              phase;
  logic [63:0]       fcnt;
  logic              done;
  logic [7:0]        held [MAX_CHANNELS];

  logic              fire;
  logic [CHAN_W-1:0] chans;
  logic [PW-1:0]     pos_eff;
  logic [PW-1:0]     pos_next;
  logic              last;
  logic [63:0]       fc_inc;
  logic              end_hit;
  logic              parity;
  logic [7:0]        marker;

  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    if (cfg.chan_count == 4'd0) begin
      chans = CHAN_W'(1);
    end else if (CHAN_W'(cfg.chan_count) > CHAN_W'(MAX_CHANNELS)) begin
      chans = CHAN_W'(MAX_CHANNELS);
    end else begin
      chans = CHAN_W'(cfg.chan_count);
    end

    // A lowered channel count restarts the frame position.
    pos_eff  = (CHAN_W'(pos) >= chans) ? '0 : pos;
    last     = (CHAN_W'(pos_eff) + CHAN_W'(1)) == chans;
    pos_next = last ? '0 : pos_eff + PW'(1);

    fc_inc  = fcnt + 64'd1;
    end_hit = last && (fc_inc >= (cfg.native ? cfg.limit_nat : cfg.limit_dop));

    if (cfg.per_sample) begin
      parity = (fcnt[0] & chans[0]) ^ pos_eff[0];
    end else begin
      parity = fcnt[0];
    end
    marker = parity ? MARK_ODD : MARK_EVEN;

    res_load = fire && !done && (cfg.native || phase);
    res.slot = 3'(pos_eff);
    res.last = end_hit;
    if (cfg.native) begin
      res.word = {16'd0, flip_byte(in_byte)};
    end else begin
      res.word = {marker, held[pos_eff], in_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= 1'b0;
      fcnt  <= '0;
      done  <= 1'b0;
    end else if (fire && !done) begin
      pos <= pos_next;
      if (cfg.native) begin
        if (last) begin
          fcnt <= fc_inc;
          done <= end_hit;
        end
      end else if (!phase) begin
        if (last) begin
          phase <= 1'b1;
        end
      end else if (last) begin
        phase <= 1'b0;
        fcnt  <= fc_inc;
        done  <= end_hit;
      end
    end
  end

  // The first frame of a pair is held for the second one.
  always_ff @(posedge clk) begin
    if (fire && !done && !cfg.native && !phase) begin
      held[pos_eff] <= in_byte;
    end
  end

`ifndef SYNTH
  a_no_result_after_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !res_load) else $error("result produced after end of stream");
  a_end_sticks: assert property (@(posedge clk) disable iff (rst)
    done |=> done) else $error("end of stream flag cleared without reset");
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (in_valid && out_free)) else $error("result loaded into a full stage");
  a_phase_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    (fire && !last) |=> $stable(phase)) else $error("pair phase moved mid-frame");
`endif

endmodule

`default_nettype wire

FILE: sv/dop_out.sv
// Result register of the DSD-over-PCM packer, driving the master-side
// stream. Depends on dop_pkg.
`default_nettype none

module dop_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_load,
  input  dop_pkg::result_t   res,
  output logic               out_free,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,
  output logic [2:0]         m_tuser,
  output logic               m_tlast
);
  import dop_pkg::*;

  result_t held_res;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held_res <= res;
    end
  end

  assign m_tdata = held_res.word;
  assign m_tuser = held_res.slot;
  assign m_tlast = held_res.last;

endmodule

`default_nettype wire

FILE: sv/dsd_over_pcm_packer_core.sv
// Top level of the DSD-over-PCM packer: configuration registers, packing
// datapath and result register. Depends on dop_pkg, dop_cfg, dop_pack, dop_out.
`default_nettype none

// Usage
// The slave stream takes one DSD byte per request, channel interleaved, eight
// one-bit samples MSB first in time. In DoP mode the bytes of one frame are
// held and each byte of the following frame yields a 24-bit word made of the
// marker (0xFA or 0x05), the held byte and the new byte; in native mode every
// byte yields its bit-reversed value at once. The master stream carries the
// word in m_tdata, the channel index in m_tuser and the end-of-stream mark in
// m_tlast. Once the frame count reaches the frame limit derived from the
// programmed sample count, further input requests are accepted and dropped
// until reset. An accepted byte waits in the input register; its result, if
// any, is then loaded into the result register, which drives m_tvalid. One
// byte is accepted every cycle while the receiver does not stall; the rate
// is set by the combinational path through the packing logic, whose longest
// part is the 64-bit frame increment and limit compare.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_tready drops; nothing is lost. Configuration writes are
// taken on the cfg channel in any cycle but must only be issued while idle.
// Synchronous reset clears the frame position, pair phase, frame counter and
// end flag and restores the register defaults; held bytes are not cleared.

module dsd_over_pcm_packer_core #(
  parameter int unsigned MAX_CHANNELS = dop_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Configuration write channel.
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data,
  // Input stream.
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] dsd_byte
  // Output stream.
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,   // [23:0] sample_word
  output logic [2:0]         m_tuser,   // [2:0] channel_slot
  output logic               m_tlast    // end_of_stream
);
  import dop_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_load;
  logic    out_free;

  dop_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dop_pack #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_pack (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  dop_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
